// ===== rtl/spit_pkg.sv =====
package spit_pkg;

  // Default coordinate width of every endpoint field.
  localparam int unsigned CoordBitsDef = 16;

  // Number of orientation tests per segment pair.
  localparam int unsigned NumOrient = 4;

  // Orientation of a point against a segment: neg for -1, zero for 0,
  // neither for +1.
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_t;

  // Load enables of the two stages inside each orientation unit.
  typedef struct packed {
    logic prod;
    logic sign;
  } pipe_en_t;

endpackage

// ===== rtl/segment_pair_intersect_test_top.sv =====
// Segment pair intersection test. Each input beat carries the endpoints of
// two 2D segments, A and B, as signed COORD_BITS-bit coordinates, and each
// output beat carries one bit that is high when the segments cross, touch at
// a point, share an endpoint or overlap along a common line. A degenerate
// segment whose endpoints coincide is handled as a single point. The block
// first rejects pairs whose bounding boxes are apart, then runs four exact
// orientation tests: the sign of a cross product, and when that is zero a
// pair of dot-product projections that place the point before, on or beyond
// the segment. All arithmetic is exact, so the answer has no rounding error.
// The datapath is a four-stage pipeline: differences and the bounding-box
// check, the products, the orientation signs, and the output register that
// combines them. A new beat may enter in every cycle, so the sustained rate
// is one pair per clock while the output side is not stalled. Each stage
// holds its beat while the stage after it is full, and an empty stage keeps
// accepting, so bubbles are squeezed out during a stall and nothing is lost
// or repeated.
// There is no configuration and no state that survives a beat.
module segment_pair_intersect_test_top #(
  parameter int unsigned COORD_BITS = spit_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] seg_a_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_a_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_a_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_a_end_y_i,
  input  logic signed [COORD_BITS-1:0] seg_b_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_b_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_b_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_b_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         intersects_o
);
  import spit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  // Stage enables. A stage loads when it is empty or when its beat moves on.
  logic en1, en2, en3, en_out;
  pipe_en_t orient_en;

  logic v1_q, v2_q, v3_q, vout_q;
  logic v1_d, v2_d, v3_d, vout_d;
  logic rej1, rej2_q, rej3_q;
  logic hit_d, hit_q;

  logic signed [DW-1:0] dir_x [NumOrient];
  logic signed [DW-1:0] dir_y [NumOrient];
  logic signed [DW-1:0] q_x   [NumOrient];
  logic signed [DW-1:0] q_y   [NumOrient];
  logic signed [DW-1:0] r_x   [NumOrient];
  logic signed [DW-1:0] r_y   [NumOrient];
  orient_t orient [NumOrient];

  assign en_out = !vout_q || out_ready_i;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign in_ready_o     = en1;
  assign orient_en.prod = en2;
  assign orient_en.sign = en3;

  spit_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (en1),
    .ax1_i    (seg_a_start_x_i),
    .ay1_i    (seg_a_start_y_i),
    .ax2_i    (seg_a_end_x_i),
    .ay2_i    (seg_a_end_y_i),
    .bx1_i    (seg_b_start_x_i),
    .by1_i    (seg_b_start_y_i),
    .bx2_i    (seg_b_end_x_i),
    .by2_i    (seg_b_end_y_i),
    .dir_x_o  (dir_x),
    .dir_y_o  (dir_y),
    .q_x_o    (q_x),
    .q_y_o    (q_y),
    .r_x_o    (r_x),
    .r_y_o    (r_y),
    .reject_o (rej1)
  );

  for (genvar i = 0; i < NumOrient; i++) begin : g_orient
    spit_orient #(
      .COORD_BITS (COORD_BITS)
    ) u_orient (
      .clk_i    (clk_i),
      .en_i     (orient_en),
      .dir_x_i  (dir_x[i]),
      .dir_y_i  (dir_y[i]),
      .q_x_i    (q_x[i]),
      .q_y_i    (q_y[i]),
      .r_x_i    (r_x[i]),
      .r_y_i    (r_y[i]),
      .orient_o (orient[i])
    );
  end

  // The bounding-box verdict rides alongside the orientation pipeline.
  always_ff @(posedge clk_i) begin
    if (en2) begin
      rej2_q <= rej1;
    end
    if (en3) begin
      rej3_q <= rej2_q;
    end
    if (en_out) begin
      hit_q <= hit_d;
    end
  end

  // Each pair of orientations must not have the same strict sign: that is,
  // one of them is zero or their signs differ.
  always_comb begin
    hit_d = !rej3_q &&
            (orient[0].zero || orient[1].zero || (orient[0].neg != orient[1].neg)) &&
            (orient[2].zero || orient[3].zero || (orient[2].neg != orient[3].neg));
  end

  always_comb begin
    v1_d   = en1    ? in_valid_i : v1_q;
    v2_d   = en2    ? v1_q       : v2_q;
    v3_d   = en3    ? v2_q       : v3_q;
    vout_d = en_out ? v3_q       : vout_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      v3_q   <= v3_d;
      vout_q <= vout_d;
    end
  end

  assign out_valid_o  = vout_q;
  assign intersects_o = hit_q;

`ifndef ASSERT_OFF
  // Back-pressure reaches the input only when every stage holds a beat.
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && vout_q))
    else $error("input stalled while a pipeline stage is empty");

  // A held beat in the first stage is never dropped.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("stage one beat lost during stall");

  // A held beat in the product stage is never dropped.
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> v2_q)
    else $error("stage two beat lost during stall");

  // A pair rejected by its bounding boxes never reports an intersection.
  a_reject_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_out && v3_q && rej3_q) |=> !intersects_o)
    else $error("bounding-box reject reported as intersecting");
`endif

endmodule

// ===== rtl/spit_front.sv =====
module spit_front #(
  parameter int unsigned COORD_BITS = spit_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] ax1_i,
  input  logic signed [COORD_BITS-1:0] ay1_i,
  input  logic signed [COORD_BITS-1:0] ax2_i,
  input  logic signed [COORD_BITS-1:0] ay2_i,
  input  logic signed [COORD_BITS-1:0] bx1_i,
  input  logic signed [COORD_BITS-1:0] by1_i,
  input  logic signed [COORD_BITS-1:0] bx2_i,
  input  logic signed [COORD_BITS-1:0] by2_i,
  output logic signed [COORD_BITS:0]   dir_x_o [spit_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   dir_y_o [spit_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   q_x_o   [spit_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   q_y_o   [spit_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   r_x_o   [spit_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   r_y_o   [spit_pkg::NumOrient],
  output logic                         reject_o
);
  import spit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [COORD_BITS-1:0] ax_min, ax_max, ay_min, ay_max;
  logic signed [COORD_BITS-1:0] bx_min, bx_max, by_min, by_max;
  logic reject_d, reject_q;
  logic signed [DW-1:0] dir_x_d [NumOrient];
  logic signed [DW-1:0] dir_y_d [NumOrient];
  logic signed [DW-1:0] q_x_d   [NumOrient];
  logic signed [DW-1:0] q_y_d   [NumOrient];
  logic signed [DW-1:0] r_x_d   [NumOrient];
  logic signed [DW-1:0] r_y_d   [NumOrient];
  logic signed [DW-1:0] dir_x_q [NumOrient];
  logic signed [DW-1:0] dir_y_q [NumOrient];
  logic signed [DW-1:0] q_x_q   [NumOrient];
  logic signed [DW-1:0] q_y_q   [NumOrient];
  logic signed [DW-1:0] r_x_q   [NumOrient];
  logic signed [DW-1:0] r_y_q   [NumOrient];

  always_comb begin
    dax = DW'(ax2_i) - DW'(ax1_i);
    day = DW'(ay2_i) - DW'(ay1_i);
    dbx = DW'(bx2_i) - DW'(bx1_i);
    dby = DW'(by2_i) - DW'(by1_i);

    // Tests 0 and 1 place the endpoints of B against A, tests 2 and 3 the
    // endpoints of A against B. The q vector runs from the segment start,
    // the r vector from the segment end.
    dir_x_d[0] = dax;  dir_y_d[0] = day;
    dir_x_d[1] = dax;  dir_y_d[1] = day;
    dir_x_d[2] = dbx;  dir_y_d[2] = dby;
    dir_x_d[3] = dbx;  dir_y_d[3] = dby;

    q_x_d[0] = DW'(bx1_i) - DW'(ax1_i);  q_y_d[0] = DW'(by1_i) - DW'(ay1_i);
    r_x_d[0] = DW'(bx1_i) - DW'(ax2_i);  r_y_d[0] = DW'(by1_i) - DW'(ay2_i);
    q_x_d[1] = DW'(bx2_i) - DW'(ax1_i);  q_y_d[1] = DW'(by2_i) - DW'(ay1_i);
    r_x_d[1] = DW'(bx2_i) - DW'(ax2_i);  r_y_d[1] = DW'(by2_i) - DW'(ay2_i);
    q_x_d[2] = DW'(ax1_i) - DW'(bx1_i);  q_y_d[2] = DW'(ay1_i) - DW'(by1_i);
    r_x_d[2] = DW'(ax1_i) - DW'(bx2_i);  r_y_d[2] = DW'(ay1_i) - DW'(by2_i);
    q_x_d[3] = DW'(ax2_i) - DW'(bx1_i);  q_y_d[3] = DW'(ay2_i) - DW'(by1_i);
    r_x_d[3] = DW'(ax2_i) - DW'(bx2_i);  r_y_d[3] = DW'(ay2_i) - DW'(by2_i);

    ax_min = (ax1_i < ax2_i) ? ax1_i : ax2_i;
    ax_max = (ax1_i < ax2_i) ? ax2_i : ax1_i;
    ay_min = (ay1_i < ay2_i) ? ay1_i : ay2_i;
    ay_max = (ay1_i < ay2_i) ? ay2_i : ay1_i;
    bx_min = (bx1_i < bx2_i) ? bx1_i : bx2_i;
    bx_max = (bx1_i < bx2_i) ? bx2_i : bx1_i;
    by_min = (by1_i < by2_i) ? by1_i : by2_i;
    by_max = (by1_i < by2_i) ? by2_i : by1_i;

    reject_d = (bx_max < ax_min) || (bx_min > ax_max) ||
               (by_max < ay_min) || (by_min > ay_max);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir_x_q  <= dir_x_d;
      dir_y_q  <= dir_y_d;
      q_x_q    <= q_x_d;
      q_y_q    <= q_y_d;
      r_x_q    <= r_x_d;
      r_y_q    <= r_y_d;
      reject_q <= reject_d;
    end
  end

  assign dir_x_o  = dir_x_q;
  assign dir_y_o  = dir_y_q;
  assign q_x_o    = q_x_q;
  assign q_y_o    = q_y_q;
  assign r_x_o    = r_x_q;
  assign r_y_o    = r_y_q;
  assign reject_o = reject_q;

endmodule

// ===== rtl/spit_orient.sv =====
module spit_orient #(
  parameter int unsigned COORD_BITS = spit_pkg::CoordBitsDef
) (
  input  logic                       clk_i,
  input  spit_pkg::pipe_en_t         en_i,
  input  logic signed [COORD_BITS:0] dir_x_i,
  input  logic signed [COORD_BITS:0] dir_y_i,
  input  logic signed [COORD_BITS:0] q_x_i,
  input  logic signed [COORD_BITS:0] q_y_i,
  input  logic signed [COORD_BITS:0] r_x_i,
  input  logic signed [COORD_BITS:0] r_y_i,
  output spit_pkg::orient_t          orient_o
);
  import spit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic signed [PW-1:0] cr_a_q, cr_b_q, d1_a_q, d1_b_q, d2_a_q, d2_b_q;
  logic signed [SW-1:0] cross_sum, dot1, dot2;
  orient_t orient_d, orient_q;

  // Stage one: six exact products, each registered on its own.
  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      cr_a_q <= q_x_i * dir_y_i;
      cr_b_q <= q_y_i * dir_x_i;
      d1_a_q <= q_x_i * dir_x_i;
      d1_b_q <= q_y_i * dir_y_i;
      d2_a_q <= r_x_i * dir_x_i;
      d2_b_q <= r_y_i * dir_y_i;
    end
  end

  // Stage two: cross product sign, with the projection fallback when the
  // point lies on the supporting line.
  always_comb begin
    cross_sum = SW'(cr_a_q) - SW'(cr_b_q);
    dot1      = SW'(d1_a_q) + SW'(d1_b_q);
    dot2      = SW'(d2_a_q) + SW'(d2_b_q);
    if (cross_sum != '0) begin
      orient_d.neg  = cross_sum[SW-1];
      orient_d.zero = 1'b0;
    end else if (dot1[SW-1] || (dot1 == '0)) begin
      orient_d.neg  = dot1[SW-1];
      orient_d.zero = (dot1 == '0);
    end else begin
      // Point is past the start; it is on the segment unless it is also
      // strictly past the end.
      orient_d.neg  = 1'b0;
      orient_d.zero = dot2[SW-1] || (dot2 == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sign) begin
      orient_q <= orient_d;
    end
  end

  assign orient_o = orient_q;

endmodule

// ===== verif/segment_pair_intersect_test_top_tb.sv =====
`timescale 1ns / 100ps

module segment_pair_intersect_test_top_tb;

  localparam int CW = spit_pkg::CoordBitsDef;

  typedef logic signed [CW-1:0] coord_t;

  // One input beat: both segments, plus a flag that makes the sender hold the
  // beat back until every result in flight has come out of the pipeline.
  typedef struct packed {
    logic   wait_for_drain;
    coord_t ax1;
    coord_t ay1;
    coord_t ax2;
    coord_t ay2;
    coord_t bx1;
    coord_t by1;
    coord_t bx2;
    coord_t by2;
  } seg_pair_t;

  // Patterns that the receiver cycles through when it applies back-pressure.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_BLOCKS
  } ready_mode_t;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      in_valid   = 1'b0;
  logic      out_ready  = 1'b0;
  seg_pair_t pair_drv   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      intersects_o;

  seg_pair_t   pending_pairs[$];
  bit          expected_hits[$];
  int          beats_in   = 0;
  int          beats_out  = 0;
  int          errors     = 0;
  int          burst_left = 1;
  int          gap_left   = 0;
  int          stall_cycle = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  segment_pair_intersect_test_top #(
    .COORD_BITS(CW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .seg_a_start_x_i(pair_drv.ax1),
    .seg_a_start_y_i(pair_drv.ay1),
    .seg_a_end_x_i  (pair_drv.ax2),
    .seg_a_end_y_i  (pair_drv.ay2),
    .seg_b_start_x_i(pair_drv.bx1),
    .seg_b_start_y_i(pair_drv.by1),
    .seg_b_end_x_i  (pair_drv.bx2),
    .seg_b_end_y_i  (pair_drv.by2),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .intersects_o   (intersects_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Coordinates are widened to 64 bits, so every difference,
  // product and sum below is exact, just like the block claims to be.
  // ---------------------------------------------------------------------------

  function automatic longint lmin(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // Where point p lies against segment 1-2: -1 for counter-clockwise or before
  // the start, +1 for clockwise or beyond the end, 0 when on the segment.
  // A collinear point is placed by projecting it on the segment direction,
  // first from the start and then from the end.
  function automatic int orientation_of(input longint x1, input longint y1,
                                        input longint x2, input longint y2,
                                        input longint px, input longint py);
    longint dx, dy, qx, qy, cr;
    dx = x2 - x1;
    dy = y2 - y1;
    qx = px - x1;
    qy = py - y1;
    cr = qx * dy - qy * dx;
    if (cr == 0) begin
      cr = qx * dx + qy * dy;
      if (cr > 0) begin
        cr = (px - x2) * dx + (py - y2) * dy;
        if (cr < 0) cr = 0;
      end
    end
    return (cr < 0) ? -1 : ((cr > 0) ? 1 : 0);
  endfunction

  function automatic bit pair_touches(input seg_pair_t p);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    int o1, o2, o3, o4;
    ax1 = $signed(p.ax1);
    ay1 = $signed(p.ay1);
    ax2 = $signed(p.ax2);
    ay2 = $signed(p.ay2);
    bx1 = $signed(p.bx1);
    by1 = $signed(p.by1);
    bx2 = $signed(p.bx2);
    by2 = $signed(p.by2);
    // Boxes that are apart can never meet.
    if (lmax(bx1, bx2) < lmin(ax1, ax2) || lmin(bx1, bx2) > lmax(ax1, ax2) ||
        lmax(by1, by2) < lmin(ay1, ay2) || lmin(by1, by2) > lmax(ay1, ay2)) begin
      return 1'b0;
    end
    o1 = orientation_of(ax1, ay1, ax2, ay2, bx1, by1);
    o2 = orientation_of(ax1, ay1, ax2, ay2, bx2, by2);
    o3 = orientation_of(bx1, by1, bx2, by2, ax1, ay1);
    o4 = orientation_of(bx1, by1, bx2, by2, ax2, ay2);
    return (o1 * o2 <= 0) && (o3 * o4 <= 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic int rand_span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic add_pair(input int ax1, input int ay1, input int ax2, input int ay2,
                          input int bx1, input int by1, input int bx2, input int by2);
    seg_pair_t p;
    p = '0;
    p.ax1 = ax1[CW-1:0];
    p.ay1 = ay1[CW-1:0];
    p.ax2 = ax2[CW-1:0];
    p.ay2 = ay2[CW-1:0];
    p.bx1 = bx1[CW-1:0];
    p.by1 = by1[CW-1:0];
    p.bx2 = bx2[CW-1:0];
    p.by2 = by2[CW-1:0];
    pending_pairs.push_back(p);
  endtask

  // Random pairs of several flavors. Uniform coordinates mostly give clean
  // crossings and misses, so most flavors are built to land on the corner
  // cases instead: collinear runs, shared endpoints, a segment end resting on
  // the other segment, and segments that have collapsed to a point.
  function automatic seg_pair_t make_random_pair();
    seg_pair_t p;
    int c[8];
    int bx, by, dx, dy, k, lo_k, hi_k, j;
    int extremes[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    p  = '0;
    bx = rand_span(-20000, 20000);
    by = rand_span(-20000, 20000);
    dx = rand_span(-60, 60);
    dy = rand_span(-60, 60);
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (c[i]) c[i] = int'($urandom());
      end
      2, 3: begin
        // A tiny grid gives many collinear and touching layouts.
        foreach (c[i]) c[i] = ((i % 2) ? by : bx) + rand_span(-4, 4);
      end
      4: begin
        // All four points on one line, in any order.
        for (int n = 0; n < 4; n++) begin
          k = rand_span(-40, 40);
          c[2*n]   = bx + k * dx;
          c[2*n+1] = by + k * dy;
        end
      end
      5: begin
        // Segment B starts or ends on an endpoint of segment A.
        foreach (c[i]) c[i] = ((i % 2) ? by : bx) + rand_span(-2000, 2000);
        j = $urandom_range(0, 1);
        k = 4 + 2 * int'($urandom_range(0, 1));
        c[k]   = c[2*j];
        c[k+1] = c[2*j+1];
      end
      6: begin
        // An endpoint of B lies on A, somewhere between its ends or on one.
        lo_k = -rand_span(1, 20);
        hi_k = rand_span(1, 20);
        c[0] = bx + lo_k * dx;
        c[1] = by + lo_k * dy;
        c[2] = bx + hi_k * dx;
        c[3] = by + hi_k * dy;
        k    = rand_span(lo_k, hi_k);
        c[4] = bx + k * dx;
        c[5] = by + k * dy;
        c[6] = bx + rand_span(-2000, 2000);
        c[7] = by + rand_span(-2000, 2000);
      end
      7: begin
        // One or both segments collapse to a point.
        foreach (c[i]) c[i] = ((i % 2) ? by : bx) + rand_span(-8, 8);
        j = $urandom_range(0, 2);
        if (j != 1) begin
          c[2] = c[0];
          c[3] = c[1];
        end
        if (j != 0) begin
          c[6] = c[4];
          c[7] = c[5];
        end
      end
      8: begin
        foreach (c[i]) c[i] = $urandom_range(0, 1) ? extremes[$urandom_range(0, 6)]
                                                   : int'($urandom());
      end
      default: begin
        foreach (c[i]) c[i] = rand_span(-1000, 1000);
      end
    endcase
    p.ax1 = c[0][CW-1:0];
    p.ay1 = c[1][CW-1:0];
    p.ax2 = c[2][CW-1:0];
    p.ay2 = c[3][CW-1:0];
    p.bx1 = c[4][CW-1:0];
    p.by1 = c[5][CW-1:0];
    p.bx2 = c[6][CW-1:0];
    p.by2 = c[7][CW-1:0];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Beats go out in bursts of random length separated by random gaps;
  // about a quarter of the gaps are empty, so long back-to-back runs happen
  // too. A beat flagged to wait for drain is held until the pipeline is empty.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    int in_flight;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      pair_drv   <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!in_valid || in_ready_o) begin
      // Beats still inside the block, counting one accepted at this edge.
      in_flight = beats_in + ((in_valid && in_ready_o) ? 1 : 0) - beats_out;
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_pairs[0].wait_for_drain && in_flight > 0) begin
        in_valid <= 1'b0;
      end else begin
        pair_drv <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= rand_span(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : rand_span(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It periodically picks a new back-pressure pattern: always ready,
  // a fair coin, mostly stalled, or alternating blocks of ready and stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      stall_cycle <= 0;
      ready_mode  <= READY_ALWAYS;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 300 == 299) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= $urandom_range(0, 1);
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= stall_cycle[2];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. The expectation for an accepted input beat is queued before the
  // output side is looked at, so the order of the two always blocks within a
  // time step cannot matter. Results come out in order, so each output beat
  // is compared against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        expected_hits.push_back(pair_touches(pair_drv));
        beats_in <= beats_in + 1;
      end
      if (out_valid_o && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("intersects: unexpected result beat, expected none, actual %0b",
                 intersects_o);
          errors++;
        end else begin
          want = expected_hits.pop_front();
          if (intersects_o !== want) begin
            $error("intersects: expected %0b, actual %0b", want, intersects_o);
            errors++;
          end
        end
        beats_out <= beats_out + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, release reset, wait for the pipeline to
  // drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    seg_pair_t p;

    // Every coordinate at the negative extreme, then at the positive one:
    // both segments collapse onto the same point.
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair( 32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767);
    // Full-range diagonals crossing near the origin; the largest differences.
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    // Full-range axes crossing.
    add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    // Boxes apart in x, then in y.
    add_pair(-32768, 0, -1, 0, 0, 0, 32767, 0);
    add_pair(0, 0, 10, 0, 0, 1, 10, 1);
    // Parallel diagonals with overlapping boxes.
    add_pair(0, 0, 10, 10, 1, 0, 11, 10);
    // Boxes overlap, both ends of B on one side of A.
    add_pair(0, 0, 10, 10, 6, 4, 10, 0);
    // Plain crossing.
    add_pair(0, 0, 4, 4, 0, 4, 4, 0);
    // Shared endpoint.
    add_pair(0, 0, 5, 5, 5, 5, 10, 0);
    // An end of B rests on the middle of A.
    add_pair(0, 0, 10, 0, 5, 0, 5, 7);
    // Collinear overlap, collinear touching end to end, and one segment
    // contained in a reversed one.
    add_pair(0, 0, 10, 0, 5, 0, 15, 0);
    add_pair(0, 0, 4, 4, 4, 4, 8, 8);
    add_pair(10, 10, 0, 0, 3, 3, 7, 7);
    // Segment A is a point on B, then a point off B inside its box.
    add_pair(3, 3, 3, 3, 0, 0, 6, 6);
    add_pair(3, 4, 3, 4, 0, 0, 6, 6);
    // Two distinct points.
    add_pair(1, 1, 1, 1, 2, 2, 2, 2);
    // Segment B is a point at an extreme endpoint of A.
    add_pair(-32768, 32767, 32767, -32768, -32768, 32767, -32768, 32767);
    // Alternating bit patterns.
    add_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);

    for (int n = 0; n < 1880; n++) begin
      p = make_random_pair();
      // Let the pipeline run dry before the random part and twice inside it.
      p.wait_for_drain = (n == 0 || n == 700 || n == 1400);
      pending_pairs.push_back(p);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled on the falling edge so the counters are settled.
    do @(negedge clk_i);
    while (pending_pairs.size() != 0 || in_valid || beats_out < beats_in);
    // Wait longer than the pipeline depth, to catch stray beats.
    repeat (20) @(negedge clk_i);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run under the heaviest stalls.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
